/* src/code_table_prefix_search_core_assert.svh */
// Assertion macros used by the block's controller, ctps_ctrl.
`ifndef CODE_TABLE_PREFIX_SEARCH_CORE_ASSERT_SVH
`define CODE_TABLE_PREFIX_SEARCH_CORE_ASSERT_SVH

// Check a property on clk_i, ignored while rst_ni is low.
`define CTPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on clk_i, also during reset.
`define CTPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/ctps_pkg.sv */
package ctps_pkg;

  localparam int TableDepth = 32768;
  localparam int MatchDepth = 4096;

  localparam int RowW   = $clog2(TableDepth);
  localparam int LimW   = $clog2(TableDepth + 1);
  localparam int MatchW = $clog2(MatchDepth);
  localparam int CntW   = $clog2(MatchDepth + 1);

  localparam int KeyW     = 16;
  localparam int NumKeys  = 4;
  localparam int CharW    = 16;
  localparam int KindW    = 2;
  localparam int RowIdxW  = 15;
  localparam int SlotW    = 12;
  localparam int RowsW    = 16;
  localparam int InDataW  = 112;
  localparam int OutDataW = 32;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_ENABLE_REGIONAL = 1'b0,
    REG_TABLE_ROWS      = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_RD_LIST,
    ST_RD_CHAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic             enable_regional;
    logic [RowsW-1:0] table_rows;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic load_we;
    logic start;
    logic scan;
    logic clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scan_done;
  } sts_t;

endpackage

/* src/code_table_prefix_search_core.sv */
// Sorted code table search.
// Input channel s_axis_*: one item per handshake; tuser carries the kind
// (load row, search, read match character, clear match count).
// Output channel m_axis_*: exactly one result per input item, in order,
// carrying match count, any-match, overflow and the read character.
// APB port: register 0 enable_regional, register 1 table_rows; write only
// while no item is in flight.
// A load passes ST_LOAD, a read ST_RD_LIST and ST_RD_CHAR, a search ST_SCAN,
// and a clear goes straight to ST_RESP, where the result is registered. The
// scan reads one table row per cycle through the key and character memories.
// One item is worked on at a time; the next item is accepted once the
// previous result sits in the output register.
// A stalled receiver holds the result; a further finished result waits in
// the controller until the register is free.
// Reset clears the match count, overflow flag, registers and handshake
// state; table contents are undefined until loaded.
module code_table_prefix_search_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_index[14:0], key_first[30:15], key_second[46:31], key_third[62:47],
  // key_fourth[78:63], row_char[94:79], row_regional[95], match_slot[107:96]
  input  logic [ctps_pkg::InDataW-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [ctps_pkg::KindW-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // match_count[12:0], any_match[13], overflow[14], match_char[30:15]
  output logic [ctps_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ctps_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ctps_pkg::ApbDataW-1:0]  pwdata,
  output logic [ctps_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  ctps_pkg::cfg_t cfg;
  ctps_pkg::cmd_t cmd;
  ctps_pkg::sts_t sts;

  ctps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ctps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctps_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .m_tdata_o (m_axis_tdata)
  );

endmodule

/* src/ctps_cfg.sv */
module ctps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ctps_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ctps_pkg::ApbDataW-1:0]  pwdata,
  output logic [ctps_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output ctps_pkg::cfg_t                 cfg_o
);

  ctps_pkg::cfg_t cfg_q, cfg_d;
  ctps_pkg::reg_e sel;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  // byte offset bits are ignored
  assign sel    = ctps_pkg::reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        ctps_pkg::REG_ENABLE_REGIONAL: cfg_d.enable_regional = pwdata[0];
        ctps_pkg::REG_TABLE_ROWS:      cfg_d.table_rows = pwdata[ctps_pkg::RowsW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      ctps_pkg::REG_ENABLE_REGIONAL: prdata = {{(ctps_pkg::ApbDataW-1){1'b0}},
                                               cfg_q.enable_regional};
      ctps_pkg::REG_TABLE_ROWS:      prdata = {{(ctps_pkg::ApbDataW-ctps_pkg::RowsW){1'b0}},
                                               cfg_q.table_rows};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ctps_dpath.sv */
module ctps_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctps_pkg::cfg_t                 cfg_i,
  input  logic [ctps_pkg::InDataW-1:0]   s_tdata_i,
  input  logic [ctps_pkg::KindW-1:0]     s_tuser_i,
  input  ctps_pkg::cmd_t                 cmd_i,
  output ctps_pkg::sts_t                 sts_o,
  output logic [ctps_pkg::OutDataW-1:0]  m_tdata_o
);

  localparam int KeyW   = ctps_pkg::KeyW;
  localparam int CharW  = ctps_pkg::CharW;
  localparam int RowW   = ctps_pkg::RowW;
  localparam int LimW   = ctps_pkg::LimW;
  localparam int MatchW = ctps_pkg::MatchW;
  localparam int CntW   = ctps_pkg::CntW;
  localparam int NumK   = ctps_pkg::NumKeys;
  localparam int OutDataW_l = ctps_pkg::OutDataW;

  // latched item
  ctps_pkg::kind_e                    kind_q;
  logic [ctps_pkg::RowIdxW-1:0]       row_q;
  logic [NumK-1:0][KeyW-1:0]          key_q;
  logic [CharW-1:0]                   char_q;
  logic                               regional_q;
  logic [ctps_pkg::SlotW-1:0]         slot_q;

  // storage
  logic [NumK*KeyW-1:0] key_mem  [ctps_pkg::TableDepth];
  logic [CharW:0]       char_mem [ctps_pkg::TableDepth];
  logic [RowW-1:0]      list_mem [ctps_pkg::MatchDepth];

  logic [NumK*KeyW-1:0] key_rd_q;
  logic [CharW:0]       char_rd_q;
  logic [RowW-1:0]      list_rd_q;
  logic [RowW-1:0]      char_raddr;

  // scan control
  logic [LimW-1:0] scan_row_q, scan_row_d;
  logic [LimW-1:0] limit_q, limit_d;
  logic            cmp_vld_q;
  logic [RowW-1:0] cmp_row_q;
  logic            in_group_q, in_group_d;
  logic            stop_q, stop_d;
  logic [CntW-1:0] total_q, total_d;
  logic            ovf_q, ovf_d;
  logic            issue;
  logic            hit_first;
  logic            row_match;
  logic            list_we;
  logic            load_ok;

  logic [OutDataW_l-1:0] out_q;
  logic [CharW-1:0]      out_char;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q     <= ctps_pkg::kind_e'(s_tuser_i);
      row_q      <= s_tdata_i[14:0];
      key_q[0]   <= s_tdata_i[30:15];
      key_q[1]   <= s_tdata_i[46:31];
      key_q[2]   <= s_tdata_i[62:47];
      key_q[3]   <= s_tdata_i[78:63];
      char_q     <= s_tdata_i[94:79];
      regional_q <= s_tdata_i[95];
      slot_q     <= s_tdata_i[107:96];
    end
  end

  assign load_ok    = 32'(row_q) < ctps_pkg::TableDepth;
  assign char_raddr = cmd_i.scan ? scan_row_q[RowW-1:0] : list_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && load_ok) begin
      key_mem[row_q[RowW-1:0]]  <= key_q;
      char_mem[row_q[RowW-1:0]] <= {regional_q, char_q};
    end
    key_rd_q  <= key_mem[scan_row_q[RowW-1:0]];
    char_rd_q <= char_mem[char_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[total_q[MatchW-1:0]] <= cmp_row_q;
    end
    list_rd_q <= list_mem[slot_q[MatchW-1:0]];
  end

  assign issue     = cmd_i.scan && !stop_q && (scan_row_q < limit_q);
  assign hit_first = key_rd_q[KeyW-1:0] == key_q[0];

  // later keys until a zero search key; regional rows fail at each compared key unless enable_regional is set
  always_comb begin
    logic active;
    active    = 1'b1;
    row_match = 1'b1;
    for (int k = 1; k < NumK; k++) begin
      active = active && (key_q[k] != '0);
      if (active && ((key_rd_q[k*KeyW +: KeyW] != key_q[k]) ||
                     (!cfg_i.enable_regional && char_rd_q[CharW]))) begin
        row_match = 1'b0;
      end
    end
  end

  assign list_we = cmp_vld_q && !stop_q && hit_first && row_match &&
                   (32'(total_q) < ctps_pkg::MatchDepth);

  always_comb begin
    scan_row_d = scan_row_q;
    limit_d    = limit_q;
    in_group_d = in_group_q;
    stop_d     = stop_q;
    total_d    = total_q;
    ovf_d      = ovf_q;
    if (cmd_i.start) begin
      scan_row_d = '0;
      limit_d    = (32'(cfg_i.table_rows) > ctps_pkg::TableDepth) ?
                   LimW'(ctps_pkg::TableDepth) : LimW'(cfg_i.table_rows);
      in_group_d = 1'b0;
      stop_d     = 1'b0;
      total_d    = '0;
      ovf_d      = 1'b0;
    end else if (cmd_i.clear) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (issue) begin
        scan_row_d = scan_row_q + 1'b1;
      end
      if (cmp_vld_q && !stop_q) begin
        if (!hit_first) begin
          // leaving the group ends the search
          stop_d = in_group_q;
        end else begin
          in_group_d = 1'b1;
          if (row_match) begin
            if (list_we) begin
              total_d = total_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_row_q <= '0;
      limit_q    <= '0;
      cmp_vld_q  <= 1'b0;
      in_group_q <= 1'b0;
      stop_q     <= 1'b0;
      total_q    <= '0;
      ovf_q      <= 1'b0;
    end else begin
      scan_row_q <= scan_row_d;
      limit_q    <= limit_d;
      cmp_vld_q  <= issue;
      in_group_q <= in_group_d;
      stop_q     <= stop_d;
      total_q    <= total_d;
      ovf_q      <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_row_q <= scan_row_q[RowW-1:0];
    end
  end

  assign out_char = ((kind_q == ctps_pkg::KIND_READ) && (CntW'(slot_q) < total_q)) ?
                    char_rd_q[CharW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {1'b0, out_char, ovf_q, (total_q != '0), total_q};
    end
  end

  assign m_tdata_o       = out_q;
  assign sts_o.kind      = ctps_pkg::kind_e'(s_tuser_i);
  assign sts_o.scan_done = stop_q || (!cmp_vld_q && (scan_row_q >= limit_q));

endmodule

/* src/ctps_ctrl.sv */
`include "code_table_prefix_search_core_assert.svh"

module ctps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  ctps_pkg::sts_t  sts_i,
  output ctps_pkg::cmd_t  cmd_o
);

  ctps_pkg::state_e state_q, state_d;
  logic             m_valid_q, m_valid_d;
  logic             accept;
  logic             out_free;

  assign s_tready_o = (state_q == ctps_pkg::ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ctps_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          unique case (sts_i.kind)
            ctps_pkg::KIND_LOAD:   state_d = ctps_pkg::ST_LOAD;
            ctps_pkg::KIND_SEARCH: begin
              cmd_o.start = 1'b1;
              state_d     = ctps_pkg::ST_SCAN;
            end
            ctps_pkg::KIND_READ:   state_d = ctps_pkg::ST_RD_LIST;
            ctps_pkg::KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = ctps_pkg::ST_RESP;
            end
          endcase
        end
      end
      ctps_pkg::ST_LOAD: begin
        cmd_o.load_we = 1'b1;
        state_d       = ctps_pkg::ST_RESP;
      end
      ctps_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ctps_pkg::ST_RESP;
        end
      end
      ctps_pkg::ST_RD_LIST: state_d = ctps_pkg::ST_RD_CHAR;
      ctps_pkg::ST_RD_CHAR: state_d = ctps_pkg::ST_RESP;
      ctps_pkg::ST_RESP: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ctps_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ctps_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

  `CTPS_ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ctps_pkg::ST_IDLE && !m_valid_q), "not idle in reset")
  `CTPS_ASSERT(a_search_scans, (accept && sts_i.kind == ctps_pkg::KIND_SEARCH) |=> (state_q == ctps_pkg::ST_SCAN), "search did not enter scan")
  `CTPS_ASSERT(a_scan_ends, (state_q == ctps_pkg::ST_SCAN && sts_i.scan_done) |=> (state_q == ctps_pkg::ST_RESP), "scan end not followed by response")
  `CTPS_ASSERT(a_resp_out, (state_q == ctps_pkg::ST_RESP && out_free) |=> (m_valid_q && state_q == ctps_pkg::ST_IDLE), "response not presented")

endmodule

/* tb/code_table_prefix_search_checker.sv */
module code_table_prefix_search_checker
  import ctps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [KindW-1:0]    s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic [ApbDataW-1:0] prdata,
  input  logic                pready,
  output int unsigned         pending_o,
  output int unsigned         fails_o
);

  typedef logic [NumKeys-1:0][KeyW-1:0] key_set_t;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic             any;
    logic             ovf;
    logic [CharW-1:0] chr;
  } outcome_t;

  key_set_t          key_mem      [TableDepth];
  logic [CharW-1:0]  char_mem     [TableDepth];
  logic              regional_mem [TableDepth];
  logic [RowIdxW-1:0] hit_rows    [MatchDepth];
  int unsigned       hit_total   = 0;
  bit                hit_ovf     = 1'b0;
  bit                regional_on = 1'b0;
  int unsigned       rows_cfg    = 0;

  outcome_t    due_results [$];
  outcome_t    want;
  int unsigned fail_count = 0;
  logic [ApbDataW-1:0] reg_value;

  assign fails_o = fail_count;

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch in %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $time);
    fail_count++;
  endtask

  // Walk rows up to the configured count; stop at the end of the first-key group.
  function automatic void scan_table(input key_set_t keys);
    int unsigned lim;
    int unsigned r;
    int unsigned k;
    bit          grp;
    bit          ok;
    lim = (rows_cfg > TableDepth) ? TableDepth : rows_cfg;
    hit_total = 0;
    hit_ovf   = 1'b0;
    grp       = 1'b0;
    for (r = 0; r < lim; r++) begin
      if (key_mem[r][0] != keys[0]) begin
        if (grp) break;
        continue;
      end
      grp = 1'b1;
      ok  = 1'b1;
      for (k = 1; k < NumKeys; k++) begin
        if (keys[k] == '0) break;
        if (key_mem[r][k] != keys[k] || (!regional_on && regional_mem[r])) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) begin
        if (hit_total < MatchDepth) begin
          hit_rows[hit_total] = r[RowIdxW-1:0];
          hit_total++;
        end else begin
          hit_ovf = 1'b1;
        end
      end
    end
  endfunction

  function automatic outcome_t apply_item(input kind_e kind, input logic [InDataW-1:0] d);
    outcome_t           o;
    logic [RowIdxW-1:0] row;
    key_set_t           keys;
    logic [SlotW-1:0]   slot;
    row  = d[14:0];
    keys = d[78:15];
    slot = d[107:96];
    o    = '0;
    case (kind)
      KIND_LOAD: begin
        key_mem[row]      = keys;
        char_mem[row]     = d[94:79];
        regional_mem[row] = d[95];
      end
      KIND_SEARCH: scan_table(keys);
      KIND_READ: begin
        if (slot < hit_total) o.chr = char_mem[hit_rows[slot]];
      end
      default: begin
        hit_total = 0;
        hit_ovf   = 1'b0;
      end
    endcase
    o.count = hit_total[CntW-1:0];
    o.any   = (hit_total != 0);
    o.ovf   = hit_ovf;
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // results leave before the item that is accepted at this same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", 0, m_axis_tdata);
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata[12:0] !== want.count)
            report_mismatch("match_count", want.count, m_axis_tdata[12:0]);
          if (m_axis_tdata[13] !== want.any)
            report_mismatch("any_match", want.any, m_axis_tdata[13]);
          if (m_axis_tdata[14] !== want.ovf)
            report_mismatch("overflow", want.ovf, m_axis_tdata[14]);
          if (m_axis_tdata[30:15] !== want.chr)
            report_mismatch("match_char", want.chr, m_axis_tdata[30:15]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(apply_item(kind_e'(s_axis_tuser), s_axis_tdata));
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_ENABLE_REGIONAL, 2'b00}) regional_on = pwdata[0];
          else if (paddr == {REG_TABLE_ROWS, 2'b00}) rows_cfg = pwdata[RowsW-1:0];
        end else begin
          reg_value = (paddr == {REG_ENABLE_REGIONAL, 2'b00}) ? ApbDataW'(regional_on)
                                                               : ApbDataW'(rows_cfg);
          if (prdata !== reg_value) report_mismatch("register read", reg_value, prdata);
        end
      end
    end
    pending_o <= due_results.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import ctps_pkg::*;

  typedef logic [NumKeys-1:0][KeyW-1:0] key_set_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  int unsigned         pending;
  int unsigned         fails;

  bit          calm = 1'b0;
  key_set_t    shadow_keys [TableDepth];
  int unsigned tbl_n = 0;

  always #5 clk_i = ~clk_i;

  code_table_prefix_search_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  code_table_prefix_search_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending_o(pending), .fails_o(fails)
  );

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic key_set_t kv(input logic [KeyW-1:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic logic [InDataW-1:0] pack_item(input logic [RowIdxW-1:0] row,
      input key_set_t keys, input logic [CharW-1:0] chr, input logic regional,
      input logic [SlotW-1:0] slot);
    return {4'b0, slot, regional, chr, keys, row};
  endfunction

  // Leave tvalid high on return; the next call or drain() sets it in this same step.
  task automatic send(input kind_e kind, input logic [InDataW-1:0] d);
    while (!calm && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_row(input int unsigned row, input key_set_t keys,
                          input logic [CharW-1:0] chr, input logic regional);
    send(KIND_LOAD, pack_item(row[RowIdxW-1:0], keys, chr, regional, 12'($urandom)));
  endtask

  task automatic search(input key_set_t keys);
    send(KIND_SEARCH, pack_item(15'($urandom), keys, 16'($urandom), 1'($urandom),
                                12'($urandom)));
  endtask

  task automatic read_slot(input int unsigned slot);
    send(KIND_READ, pack_item(15'($urandom), {$urandom, $urandom}, 16'($urandom),
                              1'($urandom), slot[SlotW-1:0]));
  endtask

  task automatic clear_count();
    send(KIND_CLEAR, pack_item(15'($urandom), {$urandom, $urandom}, 16'($urandom),
                               1'($urandom), 12'($urandom)));
  endtask

  // Write a register, then read it back.
  task automatic set_reg(input reg_e r, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Load rows 0..n-1 sorted by first key, in groups of one to five.
  task automatic build_table(input int unsigned n);
    int unsigned r;
    int unsigned grp;
    int unsigned first;
    key_set_t    keys;
    first = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom_range(65300, 65400);
    r = 0;
    while (r < n) begin
      grp = $urandom_range(1, 5);
      while (grp > 0 && r < n) begin
        keys[0] = first[KeyW-1:0];
        keys[1] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        keys[2] = 16'($urandom_range(0, 2));
        keys[3] = 16'($urandom_range(0, 2));
        shadow_keys[r] = keys;
        load_row(r, keys, 16'($urandom), $urandom_range(0, 3) == 0);
        r++;
        grp--;
      end
      first += $urandom_range(1, 3);
    end
    tbl_n = n;
  endtask

  task automatic random_op();
    int unsigned pick;
    int unsigned row;
    int unsigned depth;
    int unsigned k;
    key_set_t    keys;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      if (tbl_n > 0 && $urandom_range(0, 3) != 0) begin
        keys  = shadow_keys[$urandom_range(0, tbl_n - 1)];
        depth = $urandom_range(1, NumKeys);
        for (k = depth; k < NumKeys; k++) keys[k] = '0;
        if ($urandom_range(0, 4) == 0)
          keys[$urandom_range(1, NumKeys - 1)] = 16'($urandom_range(0, 3));
      end else begin
        keys = {$urandom, $urandom};
        if (tbl_n > 0 && $urandom_range(0, 1))
          keys[0] = shadow_keys[$urandom_range(0, tbl_n - 1)][0] + 16'd1;
      end
      search(keys);
    end else if (pick < 75) begin
      read_slot($urandom_range(0, 3) == 0 ? $urandom_range(0, MatchDepth - 1)
                                          : $urandom_range(0, 7));
    end else if (pick < 90) begin
      if (tbl_n > 0 && $urandom_range(0, 3) != 0) begin
        // rewrite in place; rarely move the row into another group
        row     = $urandom_range(0, tbl_n - 1);
        keys    = shadow_keys[row];
        keys[1] = 16'($urandom_range(0, 3));
        keys[2] = 16'($urandom_range(0, 2));
        keys[3] = 16'($urandom_range(0, 2));
        if ($urandom_range(0, 5) == 0) keys[0] = shadow_keys[$urandom_range(0, tbl_n - 1)][0];
        shadow_keys[row] = keys;
      end else begin
        row  = $urandom_range(tbl_n, TableDepth - 1);
        keys = {$urandom, $urandom};
      end
      load_row(row, keys, 16'($urandom), 1'($urandom));
    end else begin
      clear_count();
    end
  endtask

  initial begin
    int unsigned k;
    int unsigned n;
    int unsigned round;
    key_set_t    keys;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: nothing is scanned yet.
    search(kv(16'h0010, 16'h0000, 16'h0000, 16'h0000));
    read_slot(0);
    load_row(0, kv(16'h0000, 16'h0000, 16'h0000, 16'h0000), 16'h0001, 1'b0);
    load_row(1, kv(16'h0010, 16'h0001, 16'h0002, 16'h0003), 16'h1111, 1'b0);
    load_row(2, kv(16'h0010, 16'h0001, 16'h0002, 16'h0004), 16'h2222, 1'b1);
    load_row(3, kv(16'h0010, 16'h0001, 16'h0005, 16'h0000), 16'h3333, 1'b0);
    load_row(4, kv(16'h0010, 16'h0002, 16'h0002, 16'h0003), 16'h4444, 1'b0);
    load_row(5, kv(16'h0020, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'hFFFF, 1'b1);
    load_row(6, kv(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'h8000, 1'b0);
    load_row(7, kv(16'hFFFF, 16'h0001, 16'h0000, 16'h0000), 16'h7FFF, 1'b1);
    load_row(TableDepth - 1, kv(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'hFFFF, 1'b1);
    drain();
    set_reg(REG_ENABLE_REGIONAL, 0);
    set_reg(REG_TABLE_ROWS, 8);
    search(kv(16'h0010, 16'h0000, 16'h0000, 16'h0000));
    read_slot(3);
    read_slot(4);
    search(kv(16'h0010, 16'h0001, 16'h0000, 16'h0000));
    read_slot(1);
    search(kv(16'h0010, 16'h0001, 16'h0000, 16'h0003));
    search(kv(16'h0010, 16'h0001, 16'h0002, 16'h0004));
    search(kv(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    search(kv(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    search(kv(16'h0015, 16'h0000, 16'h0000, 16'h0000));
    read_slot(MatchDepth - 1);
    drain();
    set_reg(REG_ENABLE_REGIONAL, 1);
    search(kv(16'h0010, 16'h0001, 16'h0002, 16'h0004));
    read_slot(0);
    search(kv(16'hFFFF, 16'h0001, 16'h0000, 16'h0000));
    clear_count();
    read_slot(0);

    // Row count above the depth; each search ends at the close of its group.
    drain();
    set_reg(REG_TABLE_ROWS, 65535);
    search(kv(16'h0010, 16'h0000, 16'h0000, 16'h0000));
    search(kv(16'h0000, 16'h0000, 16'h0000, 16'h0000));

    // Small sorted tables, one setting per round; round 1 runs with no idling.
    for (round = 0; round < 4; round++) begin
      drain();
      calm = (round == 1);
      set_reg(REG_ENABLE_REGIONAL, round % 2);
      n = $urandom_range(4, 12);
      build_table(n);
      drain();
      set_reg(REG_TABLE_ROWS, ($urandom_range(0, 4) == 0) ? $urandom_range(0, n) : n);
      for (k = 0; k < 10; k++) random_op();
    end
    drain();
    calm = 1'b0;

    keys = shadow_keys[$urandom_range(0, tbl_n - 1)];
    search(keys);
    read_slot(0);
    clear_count();
    read_slot(0);

    drain();
    repeat (10) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
